>>> rtl/core/rrdng_pkg.sv
// Shared types, constants and helpers for the round-robin node selector.
// No dependencies; imported by rrdng_ctrl, the top module and the testbench.
package rrdng_pkg;

  localparam int MaxNodes = 16;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int CntW     = NodeW + 1;
  localparam int TimeW    = 32;

  // Configuration register indexes
  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgGraceTime = 1'b1;

  localparam logic [CntW-1:0]  NodeCountRst = CntW'(1);
  localparam logic [TimeW-1:0] GraceTimeRst = TimeW'(30);

  typedef struct packed {
    logic [CntW-1:0]  n;      // nodes in use, clamped to 1..MaxNodes
    logic [TimeW-1:0] grace;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [NodeW-1:0] node;
  } res_t;

  // Step a node index by one, wrapping at the node count.
  function automatic logic [NodeW-1:0] wrap_inc(logic [NodeW-1:0] i, logic [CntW-1:0] n);
    logic [CntW-1:0] s;
    s = {1'b0, i} + CntW'(1);
    return (s >= n) ? '0 : s[NodeW-1:0];
  endfunction

endpackage

>>> rtl/core/rrdng_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rrdng_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/rrdng_ctrl.sv
// Sequencer for the node selector: marks nodes dead, checks the grace deadline
// through the death-time RAM and scans for an alive node. Uses rrdng_pkg.
module rrdng_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrdng_pkg::cfg_t             cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [rrdng_pkg::NodeW-1:0] node_index_i,
  input  logic [rrdng_pkg::TimeW-1:0] now_i,
  output logic                        ram_we_o,
  output logic [rrdng_pkg::NodeW-1:0] ram_waddr_o,
  output logic [rrdng_pkg::TimeW-1:0] ram_wdata_o,
  output logic                        ram_re_o,
  output logic [rrdng_pkg::NodeW-1:0] ram_raddr_o,
  input  logic [rrdng_pkg::TimeW-1:0] ram_rdata_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output rrdng_pkg::res_t             res_o
);
  import rrdng_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SEval = 2'd1;
  localparam logic [1:0] SScan = 2'd2;
  localparam logic [1:0] SDone = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [NodeW-1:0]    ptr_q, ptr_d;
  logic [MaxNodes-1:0] dead_q, dead_d;   // entry holds a death time
  logic [CntW-1:0]     step_q, step_d;
  logic [NodeW-1:0]    p_q, p_d;
  logic [NodeW-1:0]    q_q, q_d;
  logic [TimeW-1:0]    now_q, now_d;
  res_t                res_q, res_d;
  logic [NodeW-1:0]    p_sel;
  logic [TimeW:0]      deadline;

  assign p_sel      = ({1'b0, ptr_q} < cfg_i.n) ? ptr_q : '0;
  assign deadline   = {1'b0, ram_rdata_i} + {1'b0, cfg_i.grace};
  assign in_stall_o = (state_q != SIdle);
  assign res_valid_o = (state_q == SDone);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    dead_d      = dead_q;
    step_d      = step_q;
    p_d         = p_q;
    q_d         = q_q;
    now_d       = now_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = node_index_i;
    ram_wdata_o = (now_i == '0) ? TimeW'(1) : now_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = p_sel;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          if (mode_i) begin
            if ({1'b0, node_index_i} < cfg_i.n) begin
              ram_we_o             = 1'b1;
              dead_d[node_index_i] = 1'b1;
            end
            res_d   = '0;
            state_d = SDone;
          end else begin
            ram_re_o = 1'b1;
            p_d      = p_sel;
            now_d    = now_i;
            state_d  = SEval;
          end
        end
      end
      SEval: begin
        if (!dead_q[p_q] || (deadline <= {1'b0, now_q})) begin
          // revive the node if it was dead and due
          dead_d[p_q] = 1'b0;
          res_d.found = 1'b1;
          res_d.node  = p_q;
          ptr_d       = wrap_inc(p_q, cfg_i.n);
          state_d     = SDone;
        end else begin
          q_d     = wrap_inc(p_q, cfg_i.n);
          step_d  = CntW'(1);
          state_d = SScan;
        end
      end
      SScan: begin
        if (step_q >= cfg_i.n) begin
          res_d   = '0;
          ptr_d   = wrap_inc(p_q, cfg_i.n);
          state_d = SDone;
        end else if (!dead_q[q_q]) begin
          res_d.found = 1'b1;
          res_d.node  = q_q;
          ptr_d       = wrap_inc(q_q, cfg_i.n);
          state_d     = SDone;
        end else begin
          q_d    = wrap_inc(q_q, cfg_i.n);
          step_d = step_q + CntW'(1);
        end
      end
      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ptr_q   <= '0;
      dead_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      dead_q  <= dead_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    q_q   <= q_d;
    now_q <= now_d;
    res_q <= res_d;
  end

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.found) |-> ({1'b0, res_o.node} < cfg_i.n))
    else $error("chosen node outside the table in use");

  a_found_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.found) |-> !dead_q[res_o.node])
    else $error("chosen node is still marked dead");

  a_mark_sets_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle && in_valid_i && mode_i && ({1'b0, node_index_i} < cfg_i.n))
    |=> dead_q[$past(node_index_i)])
    else $error("mark-dead transfer did not record the node");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> (step_q <= cfg_i.n))
    else $error("scan ran past the node count");

endmodule

>>> rtl/core/round_robin_with_dead_node_grace.sv
// Channel  | handshake                  | payload
// in       | in_valid_i / in_stall_o    | mode_i, node_index_i, now_i
// out      | out_valid_o / out_stall_i  | found_o, chosen_node_o
// cfg      | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// A mark-dead item writes the RAM and finishes; a select item reads the RAM
// and, if the pointer node is dead and not due, scans one node per cycle.
// One item is in flight at a time; the output register frees the core, so the
// next item is accepted while a result waits under out_stall_i.
// Reset marks every node alive in flip-flop flags at once; no clearing pass.
// Uses rrdng_pkg, rrdng_ram and rrdng_ctrl.
module round_robin_with_dead_node_grace (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [rrdng_pkg::TimeW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [rrdng_pkg::NodeW-1:0] node_index_i,
  input  logic [rrdng_pkg::TimeW-1:0] now_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [rrdng_pkg::NodeW-1:0] chosen_node_o
);
  import rrdng_pkg::*;

  logic [CntW-1:0]  node_count_q;
  logic [TimeW-1:0] grace_q;
  cfg_t             cfg;
  logic             ram_we, ram_re;
  logic [NodeW-1:0] ram_waddr, ram_raddr;
  logic [TimeW-1:0] ram_wdata, ram_rdata;
  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_q;
  res_t             out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountRst;
      grace_q      <= GraceTimeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNodeCount: node_count_q <= cfg_wdata_i[CntW-1:0];
        CfgGraceTime: grace_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the count to 1..MaxNodes
  always_comb begin
    if (node_count_q == '0) begin
      cfg.n = CntW'(1);
    end else if (node_count_q > CntW'(MaxNodes)) begin
      cfg.n = CntW'(MaxNodes);
    end else begin
      cfg.n = node_count_q;
    end
    cfg.grace = grace_q;
  end

  rrdng_ram #(
    .Width(TimeW),
    .Depth(MaxNodes)
  ) u_dead_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rrdng_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .node_index_i(node_index_i),
    .now_i       (now_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or when the held result transfers
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_q.found;
  assign chosen_node_o = out_q.node;

endmodule

>>> sim/tb.sv
// Testbench for round_robin_with_dead_node_grace: directed and random select and
// mark-dead transfers, checked against an in-bench round-robin predictor.
// Depends on rrdng_pkg and the block's top module.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrdng_pkg::*;

  localparam logic ModeSelect   = 1'b0;
  localparam logic ModeMarkDead = 1'b1;
  localparam int   StuckLimit   = 1000;

  typedef struct packed {
    logic             mode;
    logic [NodeW-1:0] idx;
    logic [TimeW-1:0] now;
  } conn_req_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic             cfg_idx_i     = CfgNodeCount;
  logic [TimeW-1:0] cfg_wdata_i   = '0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic             mode_i        = ModeSelect;
  logic [NodeW-1:0] node_index_i  = '0;
  logic [TimeW-1:0] now_i         = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic             found_o;
  logic [NodeW-1:0] chosen_node_o;

  // predictor state
  logic [CntW-1:0]  node_count_reg = NodeCountRst;
  logic [TimeW-1:0] grace_secs     = GraceTimeRst;
  logic [TimeW-1:0] died_at[MaxNodes];
  int               rr_ptr;

  conn_req_t send_q[$];
  res_t      owed_picks[$];
  int        idle_pct   = 12;
  int        mismatches = 0;
  int        stuck_cycles = 0;

  round_robin_with_dead_node_grace uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .node_index_i  (node_index_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .chosen_node_o (chosen_node_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int nodes_active();
    int n;
    n = int'(node_count_reg);
    if (n == 0) n = 1;
    if (n > MaxNodes) n = MaxNodes;
    return n;
  endfunction

  // Work out one transfer's result; update the table and, on a select, the pointer.
  task automatic pick_node(input logic mode, input logic [NodeW-1:0] idx,
                           input logic [TimeW-1:0] now, output res_t r);
    int n, p, q, s, chosen;
    logic [TimeW:0] due;
    n = nodes_active();
    r = '0;
    chosen = 0;
    if (mode == ModeMarkDead) begin
      if (int'(idx) < n) died_at[idx] = (now == '0) ? TimeW'(1) : now;
      return;
    end
    p = (rr_ptr < n) ? rr_ptr : 0;
    due = {1'b0, died_at[p]} + {1'b0, grace_secs};
    if (died_at[p] == '0) begin
      r.found = 1'b1;
      chosen = p;
    end else if (due <= {1'b0, now}) begin
      died_at[p] = '0;
      r.found = 1'b1;
      chosen = p;
    end else begin
      // scan the rest for a live node, no revival here
      for (s = 1; s < n; s++) begin
        q = (p + s) % n;
        if (died_at[q] == '0) begin
          r.found = 1'b1;
          chosen = q;
          break;
        end
      end
    end
    r.node = r.found ? NodeW'(chosen) : '0;
    rr_ptr = r.found ? (chosen + 1) % n : (p + 1) % n;
  endtask

  // input driver
  always @(posedge clk_i) begin
    res_t      r;
    conn_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pick_node(mode_i, node_index_i, now_i, r);
        owed_picks.push_back(r);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req = send_q.pop_front();
          in_valid_i   <= 1'b1;
          mode_i       <= req.mode;
          node_index_i <= req.idx;
          now_i        <= req.now;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_picks.size() == 0) begin
          $display("%0t: result with none owed: found=%0b node=%0d",
                   $time, found_o, chosen_node_o);
          mismatches++;
        end else begin
          want = owed_picks.pop_front();
          if (found_o !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found_o);
            mismatches++;
          end
          if (chosen_node_o !== want.node) begin
            $display("%0t: chosen_node expected %0d actual %0d",
                     $time, want.node, chosen_node_o);
            mismatches++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic queue_req(input logic m, input logic [NodeW-1:0] i,
                           input logic [TimeW-1:0] t);
    conn_req_t req;
    req.mode = m;
    req.idx  = i;
    req.now  = t;
    send_q.push_back(req);
  endtask

  task automatic write_reg(input logic idx, input logic [TimeW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx == CfgNodeCount) node_count_reg = data[CntW-1:0];
    else grace_secs = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (send_q.size() != 0 || in_valid_i || owed_picks.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    int               ph, k, n, cnt;
    logic [TimeW-1:0] wall, data;
    logic [NodeW-1:0] idx;
    logic             mode;

    for (k = 0; k < MaxNodes; k++) died_at[k] = '0;
    rr_ptr = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one node, grace 30
    queue_req(ModeSelect, 4'd0, 32'd0);
    queue_req(ModeMarkDead, 4'd0, 32'd0);    // time zero stores as 1
    queue_req(ModeSelect, 4'd0, 32'd30);     // not yet due, nothing else
    queue_req(ModeSelect, 4'd0, 32'd31);     // revive
    queue_req(ModeMarkDead, 4'd1, 32'd5);    // beyond count, dropped
    queue_req(ModeSelect, 4'd9, 32'd5);
    drain();

    write_reg(CfgNodeCount, 32'd4);
    write_reg(CfgGraceTime, 32'd10);
    queue_req(ModeMarkDead, 4'd2, 32'd100);
    queue_req(ModeSelect, 4'd0, 32'd100);
    queue_req(ModeSelect, 4'd0, 32'd100);
    queue_req(ModeSelect, 4'd0, 32'd105);    // skip dead node 2
    queue_req(ModeSelect, 4'd0, 32'd110);
    queue_req(ModeSelect, 4'd0, 32'd110);
    queue_req(ModeSelect, 4'd0, 32'd110);    // deadline exactly met
    queue_req(ModeMarkDead, 4'd15, 32'd7);
    for (k = 0; k < 4; k++) queue_req(ModeMarkDead, NodeW'(k), 32'hFFFF_FFFF);
    queue_req(ModeSelect, 4'd0, 32'hFFFF_FFFF); // deadline past 32 bits
    queue_req(ModeSelect, 4'd0, 32'd5);
    queue_req(ModeSelect, 4'd0, 32'hFFFF_FFFF);
    drain();

    // lower the count so the pointer falls outside the nodes in use
    write_reg(CfgNodeCount, 32'd2);
    write_reg(CfgGraceTime, 32'd0);
    queue_req(ModeSelect, 4'd0, 32'd0);
    queue_req(ModeSelect, 4'd0, 32'hFFFF_FFFF);
    queue_req(ModeSelect, 4'd0, 32'hFFFF_FFFE);
    drain();

    for (ph = 0; ph < 30; ph++) begin
      idle_pct = (ph >= 12 && ph < 16) ? 0 : 12;
      case (ph)
        0: cnt = 16;
        1: cnt = 0;
        2: cnt = 31;
        3: cnt = 17;
        4: cnt = 2;
        5: cnt = 1;
        default: cnt = ($urandom_range(99) < 80) ? $urandom_range(1, 16) : $urandom_range(0, 31);
      endcase
      data = $urandom_range(1) ? $urandom : '0;
      data[CntW-1:0] = CntW'(cnt);
      write_reg(CfgNodeCount, data);
      case (ph % 5)
        0: data = '0;
        1: data = 32'hFFFF_FFFF;
        2: data = $urandom_range(1, 20);
        3: data = $urandom;
        default: data = $urandom_range(21, 1000);
      endcase
      write_reg(CfgGraceTime, data);
      n = nodes_active();

      case ($urandom_range(2))
        0: wall = $urandom_range(0, 3);
        1: wall = $urandom;
        default: wall = 32'hFFFF_FFFF - $urandom_range(0, 200);
      endcase

      for (k = 0; k < 55; k++) begin
        if ($urandom_range(99) < 85) begin
          // time mostly advances in small steps, sometimes by a share of the grace
          if ($urandom_range(99) < 20)
            wall = wall + (grace_secs >> $urandom_range(2)) + $urandom_range(2) - 1;
          else
            wall = wall + $urandom_range(0, 3);
          mode = ($urandom_range(99) < 30) ? ModeMarkDead : ModeSelect;
          idx = (mode == ModeMarkDead) ? NodeW'($urandom_range(0, n - 1))
                                       : NodeW'($urandom_range(0, MaxNodes - 1));
          queue_req(mode, idx, wall);
        end else begin
          case ($urandom_range(2))
            0: data = '0;
            1: data = 32'hFFFF_FFFF;
            default: data = $urandom;
          endcase
          mode = $urandom_range(1) ? ModeMarkDead : ModeSelect;
          queue_req(mode, NodeW'($urandom_range(0, MaxNodes - 1)), data);
        end
      end
      drain();
    end

    repeat (25) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
